### rtl/rlepd_pkg.sv
`timescale 1ns / 1ps

package rlepd_pkg;

  localparam int FRAME_WIDTH_DEFAULT  = 320;
  localparam int FRAME_HEIGHT_DEFAULT = 200;
  localparam int NUM_PLANES_DEFAULT   = 4;

  localparam logic [15:0] PLANE_LENGTH_RESET = 16'd64000;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] MODE_CMD     = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;

  localparam int          LITERAL_FLAG_BIT = 7;
  localparam logic [7:0]  LITERAL_BIAS     = 8'd1;
  localparam logic [7:0]  REPEAT_BIAS      = 8'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [8:0] read_x;
    logic [7:0] read_y;
  } item_t;

  typedef struct packed {
    logic [3:0] pixel_value;
    logic       decode_done;
    logic       byte_ignored;
  } result_t;

endpackage

### rtl/rle_planar_image_decoder.sv
`timescale 1ns / 1ps

// Run-length planar image decoder. Compressed bytes (kind 0) are parsed as
// command bytes (bit 7 set: low7+1 literal bytes follow; clear: the next byte
// repeats cmd+3 times) and each data byte is plotted MSB first into a
// single-port frame store of FRAME_WIDTH x FRAME_HEIGHT pixels, NUM_PLANES bits
// each, one plane after another every plane_length pixels. One item is taken
// at a time and every item gives one result beat. A command byte, a restart,
// an unused kind or a byte after done goes straight to the result state; a
// pixel read (kind 1) first reads the frame store. A data byte writes each
// pixel directly in plane 0 and in later planes reads it and then writes it
// (frame store read, then write through the one port); a byte stops early
// when the last plane completes inside it. The result sits in an output
// register, so the next item is taken while a result beat is still stalled.
// plane_length is written through cfg_write/cfg_data; write it only while
// the block is idle, the block itself does not enforce this.
module rle_planar_image_decoder #(
  parameter int FRAME_WIDTH  = rlepd_pkg::FRAME_WIDTH_DEFAULT,
  parameter int FRAME_HEIGHT = rlepd_pkg::FRAME_HEIGHT_DEFAULT,
  parameter int NUM_PLANES   = rlepd_pkg::NUM_PLANES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [15:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  rlepd_pkg::item_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output rlepd_pkg::result_t result
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(FRAME_WIDTH);
  localparam int RW    = $clog2(FRAME_HEIGHT + 1);
  localparam int PIW   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int NP    = NUM_PLANES;
  localparam int PW    = AW + 11;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_RMEM = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]     state;
  logic [15:0]    plane_length;
  logic [CW-1:0]  column;
  logic [RW-1:0]  row;
  logic [AW-1:0]  pos_addr;
  logic [15:0]    plane_pixel_count;
  logic [PIW-1:0] plane_index;
  logic           finished;
  logic [1:0]     parse_mode;
  logic [7:0]     run_remaining;
  logic [2:0]     bit_cnt;

  logic [7:0]     byte_reg;
  logic [AW-1:0]  rd_addr;
  logic           res_read;
  logic           res_ign;

  logic [NP-1:0]  mem [DEPTH];
  logic [NP-1:0]  rd_data;
  logic [AW-1:0]  raddr;
  logic           rd_en;
  logic           mem_we;
  logic [NP-1:0]  wdata;

  logic           set_bit;
  logic [CW-1:0]  column_next;
  logic [RW-1:0]  row_next;
  logic [AW-1:0]  pos_addr_next;
  logic [15:0]    count_next;
  logic [16:0]    count_inc;
  logic [PIW-1:0] plane_index_next;
  logic           finished_next;
  logic [2:0]     pixel_state;

  logic [PW-1:0]  read_prod;
  logic           read_in_frame;
  logic [NP+3:0]  rd_ext;
  logic           load_result;

  assign item_stall = (state != S_IDLE);

  // frame store
  assign rd_en  = (state == S_RD) || (state == S_RMEM);
  assign raddr  = (state == S_RMEM) ? rd_addr : pos_addr;
  assign mem_we = (state == S_WR) && (row < RW'(FRAME_HEIGHT)) &&
                  ((plane_index == '0) || set_bit);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos_addr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
    end
  end

  // pixel step
  always_comb begin
    set_bit = byte_reg[3'd7 - bit_cnt];
    if (plane_index == '0) begin
      wdata = NP'(set_bit);
    end else begin
      wdata = rd_data | (NP'(1) << plane_index);
    end

    column_next      = column + CW'(1);
    row_next         = row;
    pos_addr_next    = pos_addr + AW'(1);
    plane_index_next = plane_index;
    finished_next    = finished;
    if (column == CW'(FRAME_WIDTH - 1)) begin
      column_next = '0;
      if (row < RW'(FRAME_HEIGHT)) begin
        row_next = row + RW'(1);
      end
    end
    count_inc  = {1'b0, plane_pixel_count} + 17'd1;
    count_next = count_inc[15:0];
    if (count_inc >= {1'b0, plane_length}) begin
      column_next   = '0;
      row_next      = '0;
      pos_addr_next = '0;
      count_next    = '0;
      if (plane_index == PIW'(NUM_PLANES - 1)) begin
        finished_next = 1'b1;
      end else begin
        plane_index_next = plane_index + PIW'(1);
      end
    end
    pixel_state = (plane_index_next == '0) ? S_WR : S_RD;
  end

  // read-back address
  assign read_prod = PW'(item.read_y) * PW'(FRAME_WIDTH) + PW'(item.read_x);
  assign read_in_frame = ({2'b0, item.read_x} < 11'(FRAME_WIDTH)) &&
                         ({3'b0, item.read_y} < 11'(FRAME_HEIGHT));
  assign rd_ext = {4'b0, rd_data};
  assign load_result = (state == S_FIN) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      plane_length      <= rlepd_pkg::PLANE_LENGTH_RESET;
      column            <= '0;
      row               <= '0;
      pos_addr          <= '0;
      plane_pixel_count <= '0;
      plane_index       <= '0;
      finished          <= 1'b0;
      parse_mode        <= rlepd_pkg::MODE_CMD;
      run_remaining     <= '0;
      bit_cnt           <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        plane_length <= cfg_data;
      end

      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            unique case (item.kind)
              rlepd_pkg::KIND_BYTE: begin
                if (finished) begin
                  state <= S_FIN;
                end else begin
                  unique case (parse_mode)
                    rlepd_pkg::MODE_LITERAL, rlepd_pkg::MODE_REPEAT: begin
                      bit_cnt <= '0;
                      state   <= (plane_index == '0) ? S_WR : S_RD;
                    end
                    default: begin
                      if (item.data_byte[rlepd_pkg::LITERAL_FLAG_BIT]) begin
                        run_remaining <= {1'b0, item.data_byte[6:0]} +
                                         rlepd_pkg::LITERAL_BIAS;
                        parse_mode    <= rlepd_pkg::MODE_LITERAL;
                      end else begin
                        run_remaining <= item.data_byte + rlepd_pkg::REPEAT_BIAS;
                        parse_mode    <= rlepd_pkg::MODE_REPEAT;
                      end
                      state <= S_FIN;
                    end
                  endcase
                end
              end
              rlepd_pkg::KIND_READ: begin
                state <= S_RMEM;
              end
              rlepd_pkg::KIND_RESTART: begin
                column            <= '0;
                row               <= '0;
                pos_addr          <= '0;
                plane_pixel_count <= '0;
                plane_index       <= '0;
                finished          <= 1'b0;
                parse_mode        <= rlepd_pkg::MODE_CMD;
                run_remaining     <= '0;
                state             <= S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          column            <= column_next;
          row               <= row_next;
          pos_addr          <= pos_addr_next;
          plane_pixel_count <= count_next;
          plane_index       <= plane_index_next;
          finished          <= finished_next;
          bit_cnt           <= bit_cnt + 3'd1;
          priority if (finished_next || (bit_cnt == 3'd7)) begin
            if (parse_mode == rlepd_pkg::MODE_LITERAL) begin
              run_remaining <= run_remaining - 8'd1;
              if (run_remaining == 8'd1) begin
                parse_mode <= rlepd_pkg::MODE_CMD;
              end
              state <= S_FIN;
            end else if (finished_next || (run_remaining == 8'd1)) begin
              run_remaining <= '0;
              parse_mode    <= rlepd_pkg::MODE_CMD;
              state         <= S_FIN;
            end else begin
              run_remaining <= run_remaining - 8'd1;
              state         <= pixel_state;
            end
          end else begin
            state <= pixel_state;
          end
        end
        S_RMEM: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (load_result) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // beat payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && item_valid) begin
      byte_reg <= item.data_byte;
      rd_addr  <= read_prod[AW-1:0];
      res_read <= (item.kind == rlepd_pkg::KIND_READ) && read_in_frame;
      res_ign  <= (item.kind == rlepd_pkg::KIND_BYTE) && finished;
    end
    if (load_result) begin
      result.pixel_value  <= res_read ? rd_ext[3:0] : 4'd0;
      result.decode_done  <= finished;
      result.byte_ignored <= res_ign;
    end
  end

endmodule
